/* hw/rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* hw/rtl/ple_pkg.sv */
// package with request codes, status codes and cell control type
package ple_pkg;

  localparam logic [3:0] REQ_PUSH_FRONT = 4'd0;
  localparam logic [3:0] REQ_PUSH_BACK  = 4'd1;
  localparam logic [3:0] REQ_INSERT     = 4'd2;
  localparam logic [3:0] REQ_READ_FIRST = 4'd3;
  localparam logic [3:0] REQ_READ_LAST  = 4'd4;
  localparam logic [3:0] REQ_READ_POS   = 4'd5;
  localparam logic [3:0] REQ_DEL_FIRST  = 4'd6;
  localparam logic [3:0] REQ_DEL_POS    = 4'd7;
  localparam logic [3:0] REQ_CLEAR      = 4'd8;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } ple_ctl_t;

endpackage

/* hw/rtl/ple_cell.sv */
// one list cell: holds one entry and shifts with its neighbors
module ple_cell import ple_pkg::*; #(
  parameter int W     = 32,
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  ple_ctl_t         ctl,
  input  logic [IDX_W-1:0] at,
  input  logic [W-1:0]     left,
  input  logic [W-1:0]     right,
  input  logic [W-1:0]     word,
  output logic [W-1:0]     value,
  output logic [W-1:0]     rd_part
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic hit;
  logic above;
  logic [W-1:0] value_next;

  assign hit   = (at == MY_IDX);
  assign above = (at < MY_IDX);

  always_comb begin
    value_next = value;
    if (ctl.ins && hit) begin
      value_next = word;
    end else if (ctl.ins && above) begin
      value_next = left;
    end else if (ctl.del && (hit || above)) begin
      value_next = right;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign rd_part = (ctl.rd && hit) ? value : '0;

endmodule

/* hw/rtl/positional_list_engine_top.sv */
// top level: request decode, length counter, row of cells, response register
//
//   channel | handshake            | payload
//   req     | req_valid/req_ready  | req_type, position, item
//   rsp     | rsp_valid/rsp_ready  | status, read_item, length
//
// one request per cycle while the response side is not stalled; its response is registered
// every insert or delete shifts the cells from its position to the end of the row in the transfer cycle
// req_ready is high while the response register is empty or being taken
// rst clears the length and the response valid; cell contents are not reset
// a stalled response holds the request side until rsp_ready returns
module positional_list_engine_top import ple_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int LEN_W = $clog2(DEPTH + 1),
  localparam int POS_W = $clog2(DEPTH + 2)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [3:0]            req_type,
  input  logic [POS_W-1:0]      position,
  input  logic [ITEM_WIDTH-1:0] item,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [1:0]            status,
  output logic [ITEM_WIDTH-1:0] read_item,
  output logic [LEN_W-1:0]      length
);

`include "assert_macros.svh"

  localparam int CMP_W = POS_W + 1;

  logic                  acc;
  logic [LEN_W-1:0]      count;
  logic [LEN_W-1:0]      count_next;
  logic [1:0]            st;
  ple_ctl_t              dec;
  ple_ctl_t              ctl;
  logic [IDX_W-1:0]      at;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic                  full;
  logic                  empty;
  logic                  pos_ok_ins;
  logic                  pos_ok_rd;
  logic [IDX_W-1:0]      pos_idx;
  logic [ITEM_WIDTH-1:0] rd_word;
  logic                  rd_req;

  logic [ITEM_WIDTH-1:0] cell_val [DEPTH];
  logic [ITEM_WIDTH-1:0] cell_rd  [DEPTH];

  assign req_ready = !rsp_valid || rsp_ready;
  assign acc       = req_valid && req_ready;

  assign pos_x      = CMP_W'(position);
  assign cnt_x      = CMP_W'(count);
  assign full       = (count == LEN_W'(DEPTH));
  assign empty      = (count == '0);
  assign pos_ok_ins = (position != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign pos_ok_rd  = (position != '0) && (pos_x <= cnt_x);
  assign pos_idx    = IDX_W'(position - POS_W'(1));
  assign rd_req     = (req_type == REQ_READ_FIRST) || (req_type == REQ_READ_LAST) ||
                      (req_type == REQ_READ_POS);

  always_comb begin
    st         = ST_OK;
    dec        = '0;
    at         = '0;
    count_next = count;
    unique case (req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        at = (req_type == REQ_PUSH_FRONT) ? '0 : IDX_W'(count);
        if (full) begin
          st = ST_FULL;
        end else begin
          dec.ins    = 1'b1;
          count_next = count + LEN_W'(1);
        end
      end
      REQ_INSERT: begin
        at = pos_idx;
        if (!pos_ok_ins) begin
          st = ST_BADPOS;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          dec.ins    = 1'b1;
          count_next = count + LEN_W'(1);
        end
      end
      REQ_READ_FIRST, REQ_READ_LAST: begin
        at = (req_type == REQ_READ_FIRST) ? '0 : IDX_W'(count - LEN_W'(1));
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          dec.rd = 1'b1;
        end
      end
      REQ_READ_POS: begin
        at = pos_idx;
        if (empty) begin
          st = ST_EMPTY;
        end else if (!pos_ok_rd) begin
          st = ST_BADPOS;
        end else begin
          dec.rd = 1'b1;
        end
      end
      REQ_DEL_FIRST: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          dec.del    = 1'b1;
          count_next = count - LEN_W'(1);
        end
      end
      REQ_DEL_POS: begin
        at = pos_idx;
        if (!pos_ok_rd) begin
          st = ST_BADPOS;
        end else begin
          dec.del    = 1'b1;
          count_next = count - LEN_W'(1);
        end
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign ctl = acc ? dec : '0;

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left;
    logic [ITEM_WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_val[i+1];
    end
    ple_cell #(
      .W     (ITEM_WIDTH),
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .at      (at),
      .left    (left),
      .right   (right),
      .word    (item),
      .value   (cell_val[i]),
      .rd_part (cell_rd[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (acc) begin
        count <= count_next;
      end
      if (acc) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status    <= st;
      read_item <= rd_word;
      length    <= count_next;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk, rst, count > LEN_W'(DEPTH), "length above depth")
  `ASSERT_CLK(a_ins_grows, clk, rst, ctl.ins |=> count == $past(count) + LEN_W'(1), "insert lost")
  `ASSERT_CLK(a_empty_read, clk, rst, (acc && empty && rd_req) |=> (status == ST_EMPTY), "empty read")
  `ASSERT_NEVER(a_rd_zero, clk, rst, rsp_valid && status != ST_OK && read_item != '0, "error data")

endmodule
